// ----- rtl/assert_macros.svh -----
// assertion macros used by the boundary face adjacency check unit
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MBFAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MBFAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mbfac_pkg.sv -----
// shared types, constants and helpers of the boundary face adjacency checker
// no dependencies
`default_nettype none

package mbfac_pkg;

    localparam int IDX_W      = 13;
    localparam int NODE_PORT_W = 20;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_OPEN     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_CHECK_CLOSED  = 2'd0,
        CFG_RECORD_ERRORS = 2'd1
    } t_cfg_idx;

    // slot order a -> b -> c -> a
    function automatic logic [1:0] next_slot(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mbfac_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module mbfac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/mesh_boundary_face_adjacency_check_unit.sv -----
// a load is written to the face ram as it is accepted; a query answer passes the pending flag
// and the output register, and no new input is taken while a query is pending.
// check: clear pass over marks up to the highest face marked by the previous check,
// then phase one reads each face and each listed neighbor in range, ending at a mismatch,
// then phase two, if enabled, reads each face; the status leaves through the output register.
// reset: synchronous, active low; a clear of all MAX_FACES entries of the error mark ram follows.
`default_nettype none

`include "assert_macros.svh"

module mesh_boundary_face_adjacency_check_unit #(
    parameter int MAX_FACES = 4096,
    parameter int NODE_BITS = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [1:0]                          i_cfg_index,
    input  wire logic                                i_cfg_data,
    // input transactions
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_mode,
    input  wire logic [mbfac_pkg::IDX_W-1:0]         i_face_index,
    input  wire logic [mbfac_pkg::IDX_W-1:0]         i_neighbor_a,
    input  wire logic [mbfac_pkg::IDX_W-1:0]         i_neighbor_b,
    input  wire logic [mbfac_pkg::IDX_W-1:0]         i_neighbor_c,
    input  wire logic [mbfac_pkg::NODE_PORT_W-1:0]   i_node_a,
    input  wire logic [mbfac_pkg::NODE_PORT_W-1:0]   i_node_b,
    input  wire logic [mbfac_pkg::NODE_PORT_W-1:0]   i_node_c,
    input  wire logic                                i_open_allowed,
    input  wire logic                                i_last,
    // result transactions
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_status,
    output logic                                     o_error_mark,
    output logic                                     o_is_query_answer
);

    localparam int IDX_W  = mbfac_pkg::IDX_W;
    localparam int CW     = $clog2(MAX_FACES + 1);
    localparam int AW     = $clog2(MAX_FACES);
    localparam int XW     = (CW + 1 > IDX_W) ? CW + 1 : IDX_W;
    localparam int ND_OFF = 3 * IDX_W;
    localparam int FW     = 3 * IDX_W + 3 * NODE_BITS + 1;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_CLEAR   = 10'b0000000010,
        S_P1_RDI  = 10'b0000000100,
        S_P1_LATI = 10'b0000001000,
        S_P1_SLOT = 10'b0000010000,
        S_P1_EVAL = 10'b0000100000,
        S_P1_MARKJ = 10'b0001000000,
        S_P2_RD   = 10'b0010000000,
        S_P2_EV   = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } t_state;

    // control registers
    t_state           r_state,  n_state;
    logic [CW-1:0]    r_count,  n_count;
    logic [CW:0]      r_i,      n_i;
    logic [1:0]       r_s,      n_s;
    logic [CW-1:0]    r_clr,    n_clr;
    logic [CW-1:0]    r_dirty,  n_dirty;
    logic             r_chk,    n_chk;
    logic             r_fault,  n_fault;
    logic             r_q_pend, n_q_pend;
    logic             r_out_valid, n_out_valid;
    logic             r_check_closed;
    logic             r_record;

    // payload registers
    logic [FW-1:0]        r_row_i,  n_row_i;
    logic [IDX_W-1:0]     r_j,      n_j;
    mbfac_pkg::t_status   r_status, n_status;
    logic                 r_q_ok,   n_q_ok;
    mbfac_pkg::t_status   r_out_status, n_out_status;
    logic                 r_out_mark,   n_out_mark;
    logic                 r_out_isq,    n_out_isq;

    // ram ports
    logic             w_face_we;
    logic [AW-1:0]    w_face_waddr;
    logic [FW-1:0]    w_face_wdata;
    logic [AW-1:0]    w_face_raddr;
    logic [FW-1:0]    w_face_rdata;
    logic             w_mark_we;
    logic [AW-1:0]    w_mark_waddr;
    logic             w_mark_wdata;
    logic [AW-1:0]    w_mark_raddr;
    logic             w_mark_rdata;

    // unpacked rows
    logic [IDX_W-1:0]     w_nb_i  [3];
    logic [NODE_BITS-1:0] w_nd_i  [3];
    logic [IDX_W-1:0]     w_nb_r  [3];
    logic [NODE_BITS-1:0] w_nd_r  [3];
    logic                 w_open_r;

    logic             w_in_ready;
    logic             w_in_acc;
    logic             w_out_free;
    logic [XW-1:0]    w_i_x, w_j_x, w_rj_x, w_cnt_x, w_q_x;
    logic [XW-1:0]    w_i_m1, w_j_m1, w_rj_m1, w_q_m1;
    logic [IDX_W-1:0] w_j;
    logic [1:0]       w_s2, w_s3, w_t, w_t2, w_t3;
    logic             w_found;
    logic             w_match;
    logic             w_open_bad;
    logic             w_mk_set;
    logic [XW-1:0]    w_mk_face;

    mbfac_ram #(.WIDTH(FW), .DEPTH(MAX_FACES)) u_face_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_face_we),
        .i_wr_addr (w_face_waddr),
        .i_wr_data (w_face_wdata),
        .i_rd_addr (w_face_raddr),
        .o_rd_data (w_face_rdata)
    );

    mbfac_ram #(.WIDTH(1), .DEPTH(MAX_FACES)) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mark_we),
        .i_wr_addr (w_mark_waddr),
        .i_wr_data (w_mark_wdata),
        .i_rd_addr (w_mark_raddr),
        .o_rd_data (w_mark_rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_nb_i[k] = r_row_i[k*IDX_W +: IDX_W];
            w_nd_i[k] = r_row_i[ND_OFF + k*NODE_BITS +: NODE_BITS];
            w_nb_r[k] = w_face_rdata[k*IDX_W +: IDX_W];
            w_nd_r[k] = w_face_rdata[ND_OFF + k*NODE_BITS +: NODE_BITS];
        end
        w_open_r = w_face_rdata[FW-1];
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_in_ready = (r_state == S_IDLE) && !r_q_pend && (!i_mode || w_out_free);
    assign w_in_acc   = i_in_valid && w_in_ready;
    assign o_in_stall = !w_in_ready;
    assign o_cfg_ready = 1'b1;

    assign w_j     = w_nb_i[r_s];
    assign w_i_x   = XW'(r_i);
    assign w_j_x   = XW'(w_j);
    assign w_rj_x  = XW'(r_j);
    assign w_cnt_x = XW'(r_count);
    assign w_q_x   = XW'(i_face_index);
    assign w_i_m1  = w_i_x - XW'(1);
    assign w_j_m1  = w_j_x - XW'(1);
    assign w_rj_m1 = w_rj_x - XW'(1);
    assign w_q_m1  = w_q_x - XW'(1);

    // neighbor row check: find the slot that lists this face, compare the reversed edge
    always_comb begin
        w_found = 1'b0;
        w_t     = 2'd0;
        for (int t = 2; t >= 0; t--) begin
            if (XW'(w_nb_r[t]) == w_i_x) begin
                w_found = 1'b1;
                w_t     = 2'(t);
            end
        end
        w_s2    = mbfac_pkg::next_slot(r_s);
        w_s3    = mbfac_pkg::next_slot(w_s2);
        w_t2    = mbfac_pkg::next_slot(w_t);
        w_t3    = mbfac_pkg::next_slot(w_t2);
        w_match = w_found && (w_nd_r[w_t3] == w_nd_i[w_s2])
                          && (w_nd_r[w_t2] == w_nd_i[w_s3]);
    end

    assign w_open_bad = ((w_nb_r[0] == '0) || (w_nb_r[1] == '0) || (w_nb_r[2] == '0))
                        && !w_open_r;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_i          = r_i;
        n_s          = r_s;
        n_clr        = r_clr;
        n_dirty      = r_dirty;
        n_chk        = r_chk;
        n_fault      = r_fault;
        n_q_pend     = 1'b0;
        n_row_i      = r_row_i;
        n_j          = r_j;
        n_status     = r_status;
        n_q_ok       = r_q_ok;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_mark   = r_out_mark;
        n_out_isq    = r_out_isq;

        w_face_we    = 1'b0;
        w_face_waddr = r_count[AW-1:0];
        w_face_wdata = {i_open_allowed, i_node_c[NODE_BITS-1:0], i_node_b[NODE_BITS-1:0],
                        i_node_a[NODE_BITS-1:0], i_neighbor_c, i_neighbor_b, i_neighbor_a};
        w_face_raddr = w_i_m1[AW-1:0];
        w_mark_we    = 1'b0;
        w_mark_waddr = w_i_m1[AW-1:0];
        w_mark_wdata = 1'b1;
        w_mark_raddr = w_q_m1[AW-1:0];
        w_mk_set     = 1'b0;
        w_mk_face    = w_i_x;

        // query answer is taken from the registered mark read while the query is pending
        if (r_q_pend) begin
            n_out_valid  = 1'b1;
            n_out_status = mbfac_pkg::ST_OK;
            n_out_mark   = r_q_ok & w_mark_rdata;
            n_out_isq    = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode) begin
                        n_q_pend = 1'b1;
                        n_q_ok   = (w_q_x != '0) && (w_q_x <= XW'(MAX_FACES));
                    end else begin
                        if (r_count < CW'(MAX_FACES)) begin
                            w_face_we = 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                        if (i_last) begin
                            n_chk   = 1'b1;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                    end
                end
            end
            S_CLEAR: begin
                if (r_clr < r_dirty) begin
                    w_mark_we    = 1'b1;
                    w_mark_waddr = r_clr[AW-1:0];
                    w_mark_wdata = 1'b0;
                    n_clr        = r_clr + 1'b1;
                end else begin
                    n_dirty = '0;
                    n_clr   = '0;
                    if (r_chk) begin
                        n_i     = (CW+1)'(1);
                        n_fault = 1'b0;
                        n_state = S_P1_RDI;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_P1_RDI: begin
                if (w_i_x > w_cnt_x) begin
                    n_i = (CW+1)'(1);
                    if (r_check_closed) begin
                        n_state = S_P2_RD;
                    end else begin
                        n_status = mbfac_pkg::ST_OK;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_P1_LATI;
                end
            end
            S_P1_LATI: begin
                n_row_i = w_face_rdata;
                n_s     = 2'd0;
                n_state = S_P1_SLOT;
            end
            S_P1_SLOT: begin
                w_face_raddr = w_j_m1[AW-1:0];
                n_j          = w_j;
                if (w_j == '0) begin
                    if (r_s == 2'd2) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_P1_RDI;
                    end else begin
                        n_s = r_s + 2'd1;
                    end
                end else if (w_j_x > w_cnt_x) begin
                    n_status = mbfac_pkg::ST_MISMATCH;
                    w_mark_we = r_record;
                    w_mk_set  = r_record;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_P1_EVAL;
                end
            end
            S_P1_EVAL: begin
                if (w_match) begin
                    if (r_s == 2'd2) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_P1_RDI;
                    end else begin
                        n_s     = r_s + 2'd1;
                        n_state = S_P1_SLOT;
                    end
                end else begin
                    n_status  = mbfac_pkg::ST_MISMATCH;
                    w_mark_we = r_record;
                    w_mk_set  = r_record;
                    n_state   = r_record ? S_P1_MARKJ : S_DONE;
                end
            end
            S_P1_MARKJ: begin
                w_mark_we    = 1'b1;
                w_mark_waddr = w_rj_m1[AW-1:0];
                w_mk_set     = 1'b1;
                w_mk_face    = w_rj_x;
                n_state      = S_DONE;
            end
            S_P2_RD: begin
                if (w_i_x > w_cnt_x) begin
                    n_status = r_fault ? mbfac_pkg::ST_OPEN : mbfac_pkg::ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_P2_EV;
                end
            end
            S_P2_EV: begin
                if (w_open_bad) begin
                    n_fault = 1'b1;
                    if (r_record) begin
                        w_mark_we = 1'b1;
                        w_mk_set  = 1'b1;
                        n_i       = r_i + 1'b1;
                        n_state   = S_P2_RD;
                    end else begin
                        n_status = mbfac_pkg::ST_OPEN;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_P2_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_mark   = 1'b0;
                    n_out_isq    = 1'b0;
                    n_count      = '0;
                    n_chk        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // track the highest marked face so the next clear pass stops there
        if (w_mk_set && (w_mk_face > XW'(r_dirty))) begin
            n_dirty = w_mk_face[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_count        <= '0;
            r_i            <= '0;
            r_s            <= '0;
            r_clr          <= '0;
            r_dirty        <= CW'(MAX_FACES);
            r_chk          <= 1'b0;
            r_fault        <= 1'b0;
            r_q_pend       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_check_closed <= 1'b0;
            r_record       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_i         <= n_i;
            r_s         <= n_s;
            r_clr       <= n_clr;
            r_dirty     <= n_dirty;
            r_chk       <= n_chk;
            r_fault     <= n_fault;
            r_q_pend    <= n_q_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mbfac_pkg::CFG_CHECK_CLOSED:  r_check_closed <= i_cfg_data;
                    mbfac_pkg::CFG_RECORD_ERRORS: r_record       <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_i      <= n_row_i;
        r_j          <= n_j;
        r_status     <= n_status;
        r_q_ok       <= n_q_ok;
        r_out_status <= n_out_status;
        r_out_mark   <= n_out_mark;
        r_out_isq    <= n_out_isq;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_error_mark      = r_out_mark;
    assign o_is_query_answer = r_out_isq;

    `MBFAC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_FACES), "face count beyond capacity")
    `MBFAC_ASSERT_NXT(a_query_lands, i_clk, i_rst_n, r_q_pend, o_out_valid && o_is_query_answer, "query answer not delivered")
    `MBFAC_ASSERT_IMP(a_slot_face, i_clk, i_rst_n, r_state == S_P1_SLOT, (r_i != '0) && (w_i_x <= w_cnt_x), "slot walk outside loaded faces")
    `MBFAC_ASSERT_NXT(a_done_emits, i_clk, i_rst_n, (r_state == S_DONE) && !r_out_valid, o_out_valid && !o_is_query_answer && (r_state == S_IDLE), "check status not delivered")

endmodule

`default_nettype wire
